// File: rtl/fba_pkg.sv
// Shared types and constants for the frame bitmap allocator.
// Used by the top level, the frame state RAM instance and the port checker.
package fba_pkg;

  localparam int TABLE_FRAMES = 4096;
  localparam int IDX_W        = $clog2(TABLE_FRAMES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int FRAME_W      = 20;
  localparam int IN_W         = 56;
  localparam int OUT_W        = 48;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [IDX_W-1:0]   index_t;
  typedef logic [1:0]         fstate_t;

  localparam frame_t ALLOC_FLOOR = 20'h00100;
  localparam frame_t BASE_RESET  = 20'd256;
  localparam frame_t LIMIT_RESET = 20'd4351;

  // Per-frame state codes held in the table.
  localparam fstate_t ST_FREE  = 2'd0;
  localparam fstate_t ST_ALLOC = 2'd1;
  localparam fstate_t ST_RSVD  = 2'd2;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_MARK    = 2'd2;
  localparam logic [1:0] OP_UNMARK  = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOMEM    = 2'd1;
  localparam logic [1:0] STAT_CONFLICT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

endpackage

// File: rtl/fba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/frame_bitmap_allocator.sv
// Physical frame allocator: top level with the frame state table and its sequencer.
// Depends on fba_pkg and fba_ram.
//
// Usage: one command beat on the s_axis group (operation, frame_number,
// last_frame, num_frames) produces exactly one result beat on the m_axis
// group (status, result_frame, free_frames, available_frames), unless a
// configuration write cuts the command short. The block works on one command
// at a time. Each command walks the frame state RAM one entry per cycle,
// reading one entry ahead while it writes back the entry before it. A scan,
// free or mark visits up to the managed frame count of table entries, and
// an allocate then also writes its run of num_frames entries.
// After reset, and after every configuration write, the block sweeps the
// table back to free, one entry per cycle over all 4096 entries, and reloads both
// counters; s_axis_tready stays low during that sweep. A finished result sits
// in the output register while the next command is accepted; if the receiver
// stalls, the following result waits in the sequencer until the register is
// taken.
module frame_bitmap_allocator (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [1:0] operation, [21:2] frame_number, [41:22] last_frame, [54:42] num_frames
  input  logic [fba_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [1:0] status, [21:2] result_frame, [34:22] free_frames, [47:35] available_frames
  output logic [fba_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                    cfg_wen,
  input  logic                    cfg_index,
  input  logic [fba_pkg::FRAME_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;

  // Configuration and values derived from it.
  fba_pkg::frame_t base;
  fba_pkg::frame_t limit;
  fba_pkg::count_t m_count;
  fba_pkg::frame_t top_frame;
  logic [fba_pkg::FRAME_W:0] base_plus_m;
  fba_pkg::count_t start_idx;
  fba_pkg::count_t alloc_span;
  logic [fba_pkg::FRAME_W:0] span;

  // Captured command.
  logic [1:0]      op_q;
  fba_pkg::frame_t fn_q;
  fba_pkg::frame_t lf_q;
  fba_pkg::count_t cnt_q;

  // Range preparation.
  fba_pkg::frame_t lo_frame;
  fba_pkg::frame_t hi_frame;
  logic            below;
  logic            over;

  // Walk over the table.
  fba_pkg::count_t idx;
  fba_pkg::count_t rem;
  logic            pend;
  fba_pkg::index_t pidx;
  fba_pkg::count_t run_len;
  fba_pkg::index_t run_start;
  fba_pkg::index_t fill_start;

  logic [1:0]      stat_q;
  fba_pkg::frame_t res_q;
  fba_pkg::count_t free_cnt;
  fba_pkg::count_t avail_cnt;

  logic            out_valid;
  logic [fba_pkg::OUT_W-1:0] out_data;

  // RAM port.
  logic              ram_we;
  fba_pkg::index_t   ram_waddr;
  fba_pkg::fstate_t  ram_wdata;
  fba_pkg::fstate_t  ram_rdata;

  logic rd_free;
  logic rd_alloc;
  logic rd_rsvd;
  logic fit;
  logic conflict;
  logic scan_end;

  fba_ram #(
    .WIDTH(2),
    .DEPTH(fba_pkg::TABLE_FRAMES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx[fba_pkg::IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign s_axis_tready = (state == S_IDLE) && !cfg_wen;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign rd_free  = (ram_rdata == fba_pkg::ST_FREE);
  assign rd_alloc = (ram_rdata == fba_pkg::ST_ALLOC);
  assign rd_rsvd  = (ram_rdata == fba_pkg::ST_RSVD);

  assign fit      = (state == S_RUN) && pend && (op_q == fba_pkg::OP_ALLOC) && rd_free &&
                    ((run_len + fba_pkg::CNT_W'(1)) >= cnt_q);
  assign conflict = (state == S_RUN) && pend && (op_q == fba_pkg::OP_FREE) && !rd_alloc;
  assign scan_end = !pend && (rem == '0);
  assign fill_start = (run_len == '0) ? pidx : run_start;

  assign span = {1'b0, limit} - {1'b0, base} + (fba_pkg::FRAME_W + 1)'(1);

  // Write-back port: the sweep, the run fill, or the entry read in the previous cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pidx;
    ram_wdata = fba_pkg::ST_FREE;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[fba_pkg::IDX_W-1:0];
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = idx[fba_pkg::IDX_W-1:0];
        ram_wdata = fba_pkg::ST_ALLOC;
      end
      S_RUN: begin
        if (pend && !scan_end) begin
          case (op_q)
            fba_pkg::OP_FREE: begin
              ram_we = rd_alloc;
            end
            fba_pkg::OP_MARK: begin
              ram_we    = !rd_rsvd;
              ram_wdata = fba_pkg::ST_RSVD;
            end
            fba_pkg::OP_UNMARK: begin
              ram_we = rd_rsvd;
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Values that follow the configuration; they settle long before the sweep ends.
  always_ff @(posedge clk) begin
    if (limit < base) begin
      m_count <= '0;
    end else if (span > (fba_pkg::FRAME_W + 1)'(fba_pkg::TABLE_FRAMES)) begin
      m_count <= fba_pkg::CNT_W'(fba_pkg::TABLE_FRAMES);
    end else begin
      m_count <= span[fba_pkg::CNT_W-1:0];
    end
    top_frame   <= base + fba_pkg::FRAME_W'(m_count) - fba_pkg::FRAME_W'(1);
    base_plus_m <= {1'b0, base} + (fba_pkg::FRAME_W + 1)'(m_count);
    start_idx   <= (base < fba_pkg::ALLOC_FLOOR) ?
                   fba_pkg::CNT_W'(fba_pkg::ALLOC_FLOOR - base) : '0;
    alloc_span  <= (start_idx < m_count) ? (m_count - start_idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      base      <= fba_pkg::BASE_RESET;
      limit     <= fba_pkg::LIMIT_RESET;
    end else begin
      // In S_DONE the output register is reloaded in the same cycle it is taken.
      if (out_valid && m_axis_tready && (cfg_wen || (state != S_DONE))) begin
        out_valid <= 1'b0;
      end

      if (cfg_wen) begin
        // A configuration write reinitializes the table and the counters.
        if (cfg_index == fba_pkg::CFG_BASE) begin
          base <= cfg_wdata;
        end else begin
          limit <= cfg_wdata;
        end
        idx   <= '0;
        state <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            idx <= idx + fba_pkg::CNT_W'(1);
            if (idx == fba_pkg::CNT_W'(fba_pkg::TABLE_FRAMES - 1)) begin
              free_cnt  <= m_count;
              avail_cnt <= m_count;
              state     <= S_IDLE;
            end
          end

          S_IDLE: begin
            if (s_axis_tvalid && s_axis_tready) begin
              op_q  <= s_axis_tdata[1:0];
              fn_q  <= s_axis_tdata[21:2];
              lf_q  <= s_axis_tdata[41:22];
              cnt_q <= s_axis_tdata[54:42];
              res_q <= '0;
              state <= S_PREP;
            end
          end

          S_PREP: begin
            below    <= fn_q < base;
            lo_frame <= (fn_q < base) ? base : fn_q;
            hi_frame <= (lf_q > top_frame) ? top_frame : lf_q;
            over     <= ({1'b0, fn_q} + (fba_pkg::FRAME_W + 1)'(cnt_q)) > base_plus_m;
            state    <= S_SETUP;
          end

          S_SETUP: begin
            pend    <= 1'b0;
            run_len <= '0;
            case (op_q)
              fba_pkg::OP_ALLOC: begin
                if (cnt_q == '0) begin
                  stat_q <= fba_pkg::STAT_OK;
                  state  <= S_DONE;
                end else begin
                  idx   <= start_idx;
                  rem   <= alloc_span;
                  state <= S_RUN;
                end
              end
              fba_pkg::OP_FREE: begin
                if (below || over) begin
                  stat_q <= fba_pkg::STAT_CONFLICT;
                  state  <= S_DONE;
                end else begin
                  idx   <= fba_pkg::CNT_W'(fn_q - base);
                  rem   <= cnt_q;
                  state <= S_RUN;
                end
              end
              default: begin
                // Mark and unmark: an empty clamped range changes nothing.
                if ((m_count == '0) || (lo_frame > hi_frame)) begin
                  stat_q <= fba_pkg::STAT_OK;
                  state  <= S_DONE;
                end else begin
                  idx   <= fba_pkg::CNT_W'(lo_frame - base);
                  rem   <= fba_pkg::CNT_W'(hi_frame - lo_frame) + fba_pkg::CNT_W'(1);
                  state <= S_RUN;
                end
              end
            endcase
          end

          S_RUN: begin
            if (fit) begin
              run_start <= fill_start;
              idx       <= fba_pkg::CNT_W'(fill_start);
              rem       <= cnt_q;
              free_cnt  <= free_cnt - cnt_q;
              pend      <= 1'b0;
              state     <= S_FILL;
            end else if (conflict) begin
              stat_q <= fba_pkg::STAT_CONFLICT;
              pend   <= 1'b0;
              state  <= S_DONE;
            end else if (scan_end) begin
              stat_q <= (op_q == fba_pkg::OP_ALLOC) ? fba_pkg::STAT_NOMEM : fba_pkg::STAT_OK;
              state  <= S_DONE;
            end else begin
              if (pend) begin
                case (op_q)
                  fba_pkg::OP_ALLOC: begin
                    run_len <= rd_free ? (run_len + fba_pkg::CNT_W'(1)) : '0;
                    if (rd_free && (run_len == '0)) begin
                      run_start <= pidx;
                    end
                  end
                  fba_pkg::OP_FREE: begin
                    free_cnt <= free_cnt + fba_pkg::CNT_W'(1);
                  end
                  fba_pkg::OP_MARK: begin
                    if (!rd_rsvd) begin
                      avail_cnt <= avail_cnt - fba_pkg::CNT_W'(1);
                    end
                    if (rd_free) begin
                      free_cnt <= free_cnt - fba_pkg::CNT_W'(1);
                    end
                  end
                  default: begin
                    if (rd_rsvd) begin
                      free_cnt  <= free_cnt + fba_pkg::CNT_W'(1);
                      avail_cnt <= avail_cnt + fba_pkg::CNT_W'(1);
                    end
                  end
                endcase
              end
              // Read one entry ahead of the one being written back.
              if (rem != '0) begin
                pend <= 1'b1;
                pidx <= idx[fba_pkg::IDX_W-1:0];
                idx  <= idx + fba_pkg::CNT_W'(1);
                rem  <= rem - fba_pkg::CNT_W'(1);
              end else begin
                pend <= 1'b0;
              end
            end
          end

          S_FILL: begin
            res_q <= base + fba_pkg::FRAME_W'(run_start);
            idx   <= idx + fba_pkg::CNT_W'(1);
            rem   <= rem - fba_pkg::CNT_W'(1);
            if (rem == fba_pkg::CNT_W'(1)) begin
              stat_q <= fba_pkg::STAT_OK;
              state  <= S_DONE;
            end
          end

          S_DONE: begin
            if (!out_valid || m_axis_tready) begin
              out_data  <= {avail_cnt, free_cnt, res_q, stat_q};
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end

          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/fba_checker.sv
// Port-level checker for the frame bitmap allocator, bound to the top level.
// Depends on fba_pkg for the result width and the status codes.
module fba_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [fba_pkg::OUT_W-1:0]    m_axis_tdata,
  input logic                         cfg_wen
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The command side is closed when reset is released, as the table sweep begins.
  a_sweep_closed: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_axis_tready)
    else $error("command accepted during table sweep");

  // A result with a failing status carries frame zero; only allocate sets a frame.
  a_result_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] != fba_pkg::STAT_OK) |-> m_axis_tdata[21:2] == '0)
    else $error("nonzero frame with failing status");

  // Free frames are a subset of the frames that are not reserved, and status 3 is never returned.
  a_counts: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[34:22] <= m_axis_tdata[47:35]) &&
                      (m_axis_tdata[1:0] != 2'd3))
    else $error("free count exceeds available count or bad status");

  // Command beats and configuration writes never share a clock edge.
  a_cfg_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> !cfg_wen)
    else $error("command accepted during a configuration write");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .cfg_wen      (cfg_wen)
);
